/* sv/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle, ignored while in reset
`define RDS_ASSERT_IMP(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("rds encoder: same-cycle check failed");

// a implies b in the next cycle, ignored while in reset
`define RDS_ASSERT_NXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("rds encoder: next-cycle check failed");

// b holds in the cycle after reset is seen
`define RDS_ASSERT_RST(lbl, ck, rs, b) \
  lbl: assert property (@(posedge ck) (rs) |=> (b)) \
    else $error("rds encoder: post-reset check failed");

`endif

/* sv/rdsenc_pkg.sv */
`default_nettype none
package rdsenc_pkg;

  localparam int DataW  = 16;
  localparam int OffW   = 10;
  localparam int BlkW   = DataW + OffW;
  localparam int LeftW  = 6;
  localparam int CntW   = 3;
  localparam int AccW   = LeftW + BlkW;
  localparam int WordW  = 32;
  localparam int QDepth = 2;

  localparam logic [OffW:0] CrcGen = 11'h5B9;
  localparam logic [1:0]    PosD   = 2'd3;

  typedef struct packed {
    logic [DataW-1:0] data_word;
    logic [OffW-1:0]  ofs_word;
  } blk_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       group_end;
  } grp_req_t;

  typedef struct packed {
    logic [BlkW-1:0] blk;
    logic            grp_last;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

  // x^(OffW+k) mod g: checkword contribution of data bit k
  function automatic logic [OffW-1:0] crc_col(input int k);
    logic [OffW:0] r;
    r = 11'h001;
    for (int i = 0; i < OffW + k; i++) begin
      r = r << 1;
      if (r[OffW]) begin
        r = r ^ CrcGen;
      end
    end
    return r[OffW-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/rdsenc_front.sv */
`default_nettype none
module rdsenc_front import rdsenc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     blk_valid,
  output logic          blk_ready,
  input  wire blk_req_t blk_data,
  input  wire logic     q_full,
  output q_port_t       push
);

  logic [1:0]      pos;
  logic [OffW-1:0] col [DataW];
  logic [OffW-1:0] check;

  for (genvar i = 0; i < DataW; i++) begin : g_col
    localparam logic [OffW-1:0] Col = crc_col(i);
    assign col[i] = blk_data.data_word[i] ? Col : '0;
  end

  always_comb begin
    check = blk_data.ofs_word;
    for (int i = 0; i < DataW; i++) begin
      check = check ^ col[i];
    end
  end

  assign blk_ready           = !q_full;
  assign push.valid          = blk_valid && !q_full;
  assign push.entry.blk      = {blk_data.data_word, check};
  assign push.entry.grp_last = (pos == PosD);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push.valid) begin
      pos <= pos + 2'd1;
    end
  end

endmodule
`default_nettype wire

/* sv/rdsenc_queue.sv */
`default_nettype none
module rdsenc_queue import rdsenc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_port_t push,
  output logic         full,
  output q_port_t      head,
  input  wire logic    pop
);

  q_entry_t   mem [QDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'(QDepth));
  assign head.valid = (count != 2'd0);
  assign head.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push.valid && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push.valid) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/rdsenc_back.sv */
`default_nettype none
module rdsenc_back import rdsenc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_port_t head,
  output logic         pop,
  output logic         grp_valid,
  input  wire logic    grp_ready,
  output grp_req_t     grp_data
);

  logic [LeftW-1:0] left_bits;
  logic [CntW-1:0]  left_cnt;
  logic [WordW-1:0] word;
  logic [2:0]       remain;
  logic             grp_flag;

  logic             emit;
  logic             load;
  logic [LeftW-1:0] old_mask;
  logic [LeftW-1:0] rem_mask;
  logic [AccW-1:0]  acc;
  logic [5:0]       total;
  logic [2:0]       nbytes;
  logic [2:0]       rem;
  logic [AccW-1:0]  tmp;
  logic [WordW-1:0] word_next;

  always_comb begin
    emit      = (remain != 3'd0) && (!grp_valid || grp_ready);
    load      = head.valid && ((remain == 3'd0) || ((remain == 3'd1) && emit));
    old_mask  = LeftW'((8'd1 << left_cnt) - 8'd1);
    acc       = {left_bits & old_mask, head.entry.blk};
    total     = 6'(left_cnt) + 6'(BlkW);
    nbytes    = total[5:3];
    rem       = total[2:0];
    rem_mask  = LeftW'((8'd1 << rem) - 8'd1);
    tmp       = acc >> rem;
    word_next = (nbytes == 3'd3) ? {tmp[23:0], 8'h00} : tmp[WordW-1:0];
  end

  assign pop = load;

  always_ff @(posedge clk) begin
    if (load) begin
      word     <= word_next;
      grp_flag <= head.entry.grp_last;
    end else if (emit) begin
      word <= word << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain    <= '0;
      left_bits <= '0;
      left_cnt  <= '0;
    end else if (load) begin
      remain    <= nbytes;
      left_bits <= acc[LeftW-1:0] & rem_mask;
      left_cnt  <= rem;
    end else if (emit) begin
      remain <= remain - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
    end else if (emit) begin
      grp_valid <= 1'b1;
    end else if (grp_ready) begin
      grp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      grp_data.out_byte  <= word[WordW-1 -: 8];
      grp_data.run_last  <= (remain == 3'd1);
      grp_data.group_end <= (remain == 3'd1) && grp_flag;
    end
  end

endmodule
`default_nettype wire

/* sv/rds_group_block_encoder_top.sv */
// RDS block encoder and group packer. Each request on blk carries a 16-bit
// information word and a 10-bit offset word; the block adds the CRC-10
// checkword (generator 0x5B9) XORed with the offset, appends the 26-bit
// block to the bit stream and sends the stream out on grp as bytes, MSB
// first. Blocks A, B and C give three bytes each and block D four, so a
// group is thirteen bytes; run_last marks the last byte of each block and
// group_end the last byte of the group. The checkword is computed in the
// cycle a request is taken, and a two-entry queue decouples that side from
// the byte packer. The output port moves one byte per cycle while grp_ready
// is high and blocks are queued. The first byte of a block passes through
// the queue entry, the packer word register and the output byte register.
`default_nettype none
module rds_group_block_encoder_top import rdsenc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     blk_valid,
  output logic          blk_ready,
  input  wire blk_req_t blk_data,
  output logic          grp_valid,
  input  wire logic     grp_ready,
  output grp_req_t      grp_data
);

  q_port_t push;
  q_port_t head;
  logic    q_full;
  logic    pop;

  rdsenc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk_data  (blk_data),
    .q_full    (q_full),
    .push      (push)
  );

  rdsenc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  rdsenc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp_data  (grp_data)
  );

endmodule
`default_nettype wire

/* sv/rdsenc_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module rdsenc_checker import rdsenc_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     blk_valid,
  input wire logic     blk_ready,
  input wire blk_req_t blk_data,
  input wire logic     grp_valid,
  input wire logic     grp_ready,
  input wire grp_req_t grp_data
);

  `RDS_ASSERT_IMP(a_end_is_last, clk, rst, grp_valid && grp_data.group_end, grp_data.run_last)
  `RDS_ASSERT_NXT(a_out_hold, clk, rst, grp_valid && !grp_ready, grp_valid && $stable(grp_data))
  `RDS_ASSERT_NXT(a_in_hold, clk, rst, blk_valid && !blk_ready, blk_valid && $stable(blk_data))
  `RDS_ASSERT_RST(a_rst_out_idle, clk, rst, !grp_valid)
  `RDS_ASSERT_RST(a_rst_in_ready, clk, rst, blk_ready)

endmodule

bind rds_group_block_encoder_top rdsenc_checker u_chk (.*);
`default_nettype wire
